[sv/dmc_pkg.sv]
`timescale 1ns / 1ps
package dmc_pkg;

    // Grid geometry
    localparam int MAX_SIDE = 64;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int CRD_W    = SIDE_W + 1;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int SP_W     = ADDR_W + 1;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CELL_W   = 5;
    localparam int RND_W    = 32;
    localparam int ACT_W    = 2;

    // Cell bits
    localparam logic [CELL_W-1:0] OPEN_N = 5'h01;
    localparam logic [CELL_W-1:0] OPEN_E = 5'h02;
    localparam logic [CELL_W-1:0] OPEN_S = 5'h04;
    localparam logic [CELL_W-1:0] OPEN_W = 5'h08;
    localparam logic [CELL_W-1:0] SEEN   = 5'h10;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_START,
        ACT_STEP,
        ACT_READ,
        ACT_NONE
    } t_action;

    typedef enum logic [1:0] {
        DIR_N,
        DIR_E,
        DIR_S,
        DIR_W
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT
    } t_reg_idx;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]        pad;
        logic [RND_W-1:0]  random_value;
        logic [SIDE_W-1:0] pos_y;
        logic [SIDE_W-1:0] pos_x;
    } t_in_word;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [CELL_W-1:0] cell_walls;
        logic              done_res;
        t_dir              direction;
        logic              carved;
        logic [SIDE_W-1:0] cell_y;
        logic [SIDE_W-1:0] cell_x;
    } t_out_word;

    localparam int IN_W  = $bits(t_in_word);
    localparam int OUT_W = $bits(t_out_word);

    // Clamp a configured side to 1..MAX_SIDE
    function automatic logic [CRD_W-1:0] eff_side(input logic [CFG_W-1:0] v);
        logic [CRD_W-1:0] r;
        if (v == '0) begin
            r = CRD_W'(1);
        end else if (v > CFG_W'(MAX_SIDE)) begin
            r = CRD_W'(MAX_SIDE);
        end else begin
            r = CRD_W'(v);
        end
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] wall_bit(input t_dir d);
        logic [CELL_W-1:0] r;
        case (d)
            DIR_N:   r = OPEN_N;
            DIR_E:   r = OPEN_E;
            DIR_S:   r = OPEN_S;
            default: r = OPEN_W;
        endcase
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] back_bit(input t_dir d);
        logic [CELL_W-1:0] r;
        case (d)
            DIR_N:   r = OPEN_S;
            DIR_E:   r = OPEN_W;
            DIR_S:   r = OPEN_N;
            default: r = OPEN_E;
        endcase
        return r;
    endfunction

    // Neighbor column; an underflow lands above MAX_SIDE and fails the bound check
    function automatic logic [CRD_W-1:0] step_x(input logic [SIDE_W-1:0] c, input t_dir d);
        logic [CRD_W-1:0] r;
        case (d)
            DIR_E:   r = CRD_W'(c) + CRD_W'(1);
            DIR_W:   r = CRD_W'(c) - CRD_W'(1);
            default: r = CRD_W'(c);
        endcase
        return r;
    endfunction

    function automatic logic [CRD_W-1:0] step_y(input logic [SIDE_W-1:0] c, input t_dir d);
        logic [CRD_W-1:0] r;
        case (d)
            DIR_N:   r = CRD_W'(c) - CRD_W'(1);
            DIR_S:   r = CRD_W'(c) + CRD_W'(1);
            default: r = CRD_W'(c);
        endcase
        return r;
    endfunction

    // Word mod 3: base-4 digits sum in a tree, then fold
    function automatic logic [1:0] mod3_32(input logic [RND_W-1:0] v);
        logic [2:0] l1 [8];
        logic [3:0] l2 [4];
        logic [4:0] l3 [2];
        logic [5:0] s;
        logic [3:0] t;
        for (int i = 0; i < 8; i++) begin
            l1[i] = 3'(v[4*i +: 2]) + 3'(v[4*i+2 +: 2]);
        end
        for (int i = 0; i < 4; i++) begin
            l2[i] = 4'(l1[2*i]) + 4'(l1[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            l3[i] = 5'(l2[2*i]) + 5'(l2[2*i+1]);
        end
        s = 6'(l3[0]) + 6'(l3[1]);
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        if (t >= 4'd6) begin
            t = t - 4'd6;
        end
        if (t >= 4'd3) begin
            t = t - 4'd3;
        end
        return t[1:0];
    endfunction

    // Direction of the k-th set bit of the open mask, in N, E, S, W order
    function automatic t_dir pick_dir(input logic [3:0] mask, input logic [1:0] k);
        logic [2:0] cnt;
        t_dir       d;
        cnt = '0;
        d   = DIR_N;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                if (cnt == {1'b0, k}) begin
                    d = t_dir'(2'(i));
                end
                cnt = cnt + 3'd1;
            end
        end
        return d;
    endfunction

endpackage

[sv/dmc_ram.sv]
`timescale 1ns / 1ps
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dfs_maze_carver_core.sv]
`timescale 1ns / 1ps
// Depth-first maze carver on a grid of up to 64 by 64 cells. Cell bits (north,
// east, south, west openings and a visited flag) sit in one 4096-entry RAM and
// the path of coordinates in a second 4096-entry RAM; every item works by reading,
// modifying and writing these one access a cycle, so one item is in flight at a
// time. A read item issues its cell read on accept, then loads the result. A step
// that carves reads the current cell and four neighbors, writes two cells with the
// stack push, then re-reads the new stack top; one that backtracks pops instead of
// writing. A carve that finishes the maze then reads and rewrites two cells to open
// the entrance and exit. A start item first clears the cell RAM one entry a cycle;
// until the first start every cell reads as zero. The result register lets the
// next word in while a result waits. The user must write the grid size over the
// config port only while the block is idle; the block itself does not enforce this.
module dfs_maze_carver_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x[5:0], pos_y[11:6], random_value[43:12], zero pad[47:44]
    input  logic [dmc_pkg::IN_W-1:0]          s_axis_tdata,
    // action[1:0]
    input  logic [dmc_pkg::ACT_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cell_x[5:0], cell_y[11:6], carved[12], direction[14:13], done_res[15],
    // cell_walls[20:16], zero pad[23:21]
    output logic [dmc_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]         i_cfg_data
);

    import dmc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_START,
        S_TOP,
        S_CUR,
        S_NB,
        S_LAST,
        S_PICK,
        S_WCUR,
        S_WNB,
        S_OE0,
        S_OE1,
        S_OE2,
        S_OE3,
        S_RTOP,
        S_RLAT,
        S_RDONE,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_grid_w;
    logic [CFG_W-1:0]    r_grid_h;
    logic [SP_W-1:0]     r_sp;
    logic [SP_W-1:0]     r_visited;
    logic                r_clean;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [SIDE_W-1:0]   r_px;
    logic [SIDE_W-1:0]   r_py;
    logic [RND_W-1:0]    r_rnd;
    logic [1:0]          r_rmod3;
    logic [SIDE_W-1:0]   r_cx;
    logic [SIDE_W-1:0]   r_cy;
    logic [1:0]          r_k;
    logic [CELL_W-1:0]   r_cur;
    logic [CELL_W-1:0]   r_nb [4];
    logic [SIDE_W-1:0]   r_x;
    logic [SIDE_W-1:0]   r_y;
    logic                r_carved;
    t_dir                r_dir;
    logic [CELL_W-1:0]   r_walls;
    logic                r_m_valid;
    t_out_word           r_m_word;

    t_in_word            in_word;
    t_action             in_act;
    logic                in_fire;
    logic [CRD_W-1:0]    eff_w;
    logic [CRD_W-1:0]    eff_h;
    logic [CRD_W-1:0]    w_m1;
    logic [CRD_W-1:0]    h_m1;
    logic [2*CRD_W-1:0]  area;
    logic                done_now;
    logic                one_cell;
    logic [SIDE_W-1:0]   px_sat;
    logic [SIDE_W-1:0]   py_sat;
    logic [SP_W-1:0]     sp_dec;
    logic                sp_room;
    logic [CELL_W-1:0]   start_val;
    logic [3:0]          inb;
    logic [3:0]          open_mask;
    logic [2:0]          open_cnt;
    logic [1:0]          pick_k;
    t_dir                pick_d;
    logic [CRD_W-1:0]    k_nx;
    logic [CRD_W-1:0]    k_ny;
    logic [CRD_W-1:0]    d_nx;
    logic [CRD_W-1:0]    d_ny;
    logic [ADDR_W-1:0]   k_addr;
    logic [ADDR_W-1:0]   d_addr;
    logic [ADDR_W-1:0]   corner;

    logic                c_we;
    logic [ADDR_W-1:0]   c_waddr;
    logic [CELL_W-1:0]   c_wdata;
    logic                c_re;
    logic [ADDR_W-1:0]   c_raddr;
    logic [CELL_W-1:0]   c_rdata;
    logic [CELL_W-1:0]   cell_rd;
    logic                p_we;
    logic [ADDR_W-1:0]   p_waddr;
    logic [ADDR_W-1:0]   p_wdata;
    logic                p_re;
    logic [ADDR_W-1:0]   p_raddr;
    logic [ADDR_W-1:0]   p_rdata;

    // Input decode and handshakes
    assign in_word       = t_in_word'(s_axis_tdata);
    assign in_act        = t_action'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_word;

    // Grid size, completion and clamped positions
    assign eff_w    = eff_side(r_grid_w);
    assign eff_h    = eff_side(r_grid_h);
    assign w_m1     = eff_w - CRD_W'(1);
    assign h_m1     = eff_h - CRD_W'(1);
    assign area     = eff_w * eff_h;
    assign done_now = (2*CRD_W)'(r_visited) >= area;
    assign one_cell = (eff_w == CRD_W'(1)) && (eff_h == CRD_W'(1));
    assign px_sat   = (CRD_W'(in_word.pos_x) > w_m1) ? w_m1[SIDE_W-1:0] : in_word.pos_x;
    assign py_sat   = (CRD_W'(in_word.pos_y) > h_m1) ? h_m1[SIDE_W-1:0] : in_word.pos_y;
    assign corner   = {h_m1[SIDE_W-1:0], w_m1[SIDE_W-1:0]};
    assign start_val = one_cell ? (SEEN | OPEN_N | OPEN_S) : SEEN;

    assign sp_dec   = r_sp - SP_W'(1);
    assign sp_room  = (r_sp != SP_W'(DEPTH));

    // Cells read as zero until the first clearing pass
    assign cell_rd  = r_clean ? '0 : c_rdata;

    // Neighbor being read and neighbor chosen
    assign k_nx   = step_x(r_cx, t_dir'(r_k));
    assign k_ny   = step_y(r_cy, t_dir'(r_k));
    assign k_addr = {k_ny[SIDE_W-1:0], k_nx[SIDE_W-1:0]};
    assign d_nx   = step_x(r_cx, r_dir);
    assign d_ny   = step_y(r_cy, r_dir);
    assign d_addr = {d_ny[SIDE_W-1:0], d_nx[SIDE_W-1:0]};

    // Open neighbors: in bounds and not yet visited
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            inb[i] = (step_x(r_cx, t_dir'(2'(i))) < eff_w) &&
                     (step_y(r_cy, t_dir'(2'(i))) < eff_h);
            open_mask[i] = inb[i] && !r_nb[i][CELL_W-1];
        end
        open_cnt = 3'(open_mask[0]) + 3'(open_mask[1]) + 3'(open_mask[2])
                 + 3'(open_mask[3]);
        case (open_cnt)
            3'd2:    pick_k = {1'b0, r_rnd[0]};
            3'd3:    pick_k = r_rmod3;
            3'd4:    pick_k = r_rnd[1:0];
            default: pick_k = 2'd0;
        endcase
        pick_d = pick_dir(open_mask, pick_k);
    end

    // Memory port control per state
    always_comb begin
        c_we    = 1'b0;
        c_waddr = '0;
        c_wdata = '0;
        c_re    = 1'b0;
        c_raddr = '0;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_re    = 1'b0;
        p_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire && in_act == ACT_READ) begin
                    c_re    = 1'b1;
                    c_raddr = {py_sat, px_sat};
                end
            end
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = r_clr_addr;
            end
            S_START: begin
                c_we    = 1'b1;
                c_waddr = {r_py, r_px};
                c_wdata = start_val;
                p_we    = 1'b1;
                p_wdata = {r_py, r_px};
            end
            S_TOP: begin
                p_re    = 1'b1;
                p_raddr = sp_dec[ADDR_W-1:0];
            end
            S_CUR: begin
                c_re    = 1'b1;
                c_raddr = p_rdata;
            end
            S_NB: begin
                c_re    = 1'b1;
                c_raddr = k_addr;
            end
            S_WCUR: begin
                c_we    = 1'b1;
                c_waddr = {r_cy, r_cx};
                c_wdata = r_cur | wall_bit(r_dir);
                p_we    = sp_room;
                p_waddr = r_sp[ADDR_W-1:0];
                p_wdata = d_addr;
            end
            S_WNB: begin
                c_we    = 1'b1;
                c_waddr = d_addr;
                c_wdata = r_nb[r_dir] | back_bit(r_dir) | SEEN;
            end
            S_OE0: begin
                c_re    = 1'b1;
            end
            S_OE1: begin
                c_we    = 1'b1;
                c_wdata = cell_rd | OPEN_N;
            end
            S_OE2: begin
                c_re    = 1'b1;
                c_raddr = corner;
            end
            S_OE3: begin
                c_we    = 1'b1;
                c_waddr = corner;
                c_wdata = cell_rd | OPEN_S;
            end
            S_RTOP: begin
                p_re    = (r_sp != '0);
                p_raddr = sp_dec[ADDR_W-1:0];
            end
            S_RLAT: begin
                c_re    = 1'b1;
                c_raddr = p_rdata;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, state registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_grid_w  <= GRID_RESET;
            r_grid_h  <= GRID_RESET;
            r_sp      <= '0;
            r_visited <= '0;
            r_clean   <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            // take register writes
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                    REG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // drop the result word once taken; the output state reloads it itself
            if (r_m_valid && m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_px     <= px_sat;
                        r_py     <= py_sat;
                        r_rnd    <= in_word.random_value;
                        r_carved <= 1'b0;
                        r_dir    <= DIR_N;
                        case (in_act)
                            ACT_START: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLR;
                            end
                            ACT_READ: begin
                                r_x     <= px_sat;
                                r_y     <= py_sat;
                                r_state <= S_RDONE;
                            end
                            ACT_STEP: begin
                                r_state <= (r_sp != '0 && !done_now) ? S_TOP : S_RTOP;
                            end
                            default: begin
                                r_state <= S_RTOP;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1) begin
                        r_clean <= 1'b0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_sp      <= SP_W'(1);
                    r_visited <= SP_W'(1);
                    r_x       <= r_px;
                    r_y       <= r_py;
                    r_walls   <= start_val;
                    r_state   <= S_OUT;
                end
                S_TOP: begin
                    r_state <= S_CUR;
                end
                S_CUR: begin
                    r_cx    <= p_rdata[SIDE_W-1:0];
                    r_cy    <= p_rdata[ADDR_W-1:SIDE_W];
                    r_rmod3 <= mod3_32(r_rnd);
                    r_k     <= '0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    // capture the previous read while issuing the next
                    if (r_k == '0) begin
                        r_cur <= cell_rd;
                    end else begin
                        r_nb[r_k - 2'd1] <= cell_rd;
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_nb[3] <= cell_rd;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (open_cnt == '0) begin
                        r_sp    <= sp_dec;
                        r_state <= S_RTOP;
                    end else begin
                        r_dir    <= pick_d;
                        r_carved <= 1'b1;
                        r_state  <= S_WCUR;
                    end
                end
                S_WCUR: begin
                    if (sp_room) begin
                        r_sp <= r_sp + SP_W'(1);
                    end
                    r_visited <= r_visited + SP_W'(1);
                    r_state   <= S_WNB;
                end
                S_WNB: begin
                    r_state <= done_now ? S_OE0 : S_RTOP;
                end
                S_OE0: begin
                    r_state <= S_OE1;
                end
                S_OE1: begin
                    r_state <= S_OE2;
                end
                S_OE2: begin
                    r_state <= S_OE3;
                end
                S_OE3: begin
                    r_state <= S_RTOP;
                end
                S_RTOP: begin
                    if (r_sp == '0) begin
                        r_x     <= '0;
                        r_y     <= '0;
                        r_walls <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RLAT;
                    end
                end
                S_RLAT: begin
                    r_x     <= p_rdata[SIDE_W-1:0];
                    r_y     <= p_rdata[ADDR_W-1:SIDE_W];
                    r_state <= S_RDONE;
                end
                S_RDONE: begin
                    r_walls <= cell_rd;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid           <= 1'b1;
                        r_m_word.pad        <= '0;
                        r_m_word.cell_x     <= r_x;
                        r_m_word.cell_y     <= r_y;
                        r_m_word.carved     <= r_carved;
                        r_m_word.direction  <= r_dir;
                        r_m_word.done_res   <= done_now;
                        r_m_word.cell_walls <= r_walls;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    dmc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    dmc_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (DEPTH)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

endmodule

[sv/dmc_checker.sv]
`timescale 1ns / 1ps
module dmc_props (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [dmc_pkg::IN_W-1:0]          s_axis_tdata,
    input  logic [dmc_pkg::ACT_W-1:0]         s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [dmc_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]         i_cfg_data
);

    import dmc_pkg::*;

    t_out_word out_word;

    assign out_word = t_out_word'(m_axis_tdata);

    // One word in flight: the input side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // No carve means no direction
    a_dir_without_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !out_word.carved) |-> (out_word.direction == DIR_N))
        else $error("direction set on a word that carved nothing");

    // Pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_word.pad == '0))
        else $error("result pad bits not zero");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

bind dfs_maze_carver_core dmc_props u_dmc_props (.*);
